// ===== rtl/core/field25519_exponent_unit_macros.svh =====
// Assertion helpers for the field exponent unit.
`ifndef FIELD25519_EXPONENT_UNIT_MACROS_SVH
`define FIELD25519_EXPONENT_UNIT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define FEU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define FEU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/f25519_pkg.sv =====
package f25519_pkg;

  localparam int FeW = 255;
  localparam int DigW = 4;
  localparam int NDig = 64;
  localparam int CntW = 6;

  localparam logic [FeW-1:0] PrimeP =
    255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffed;
  localparam logic [FeW-1:0] SqrtM1 =
    255'h2b8324804fc1df0b2b4d00993dfbd7a72f431806ad2fe478c4ee1b274a0ea0b0;
  localparam logic [FeW-1:0] ExpInv =
    255'h7fffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffeb;
  localparam logic [FeW-1:0] Exp22523 =
    255'h0ffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffffd;

  typedef enum logic [1:0] {
    OP_INV  = 2'd0,
    OP_POW  = 2'd1,
    OP_SQRT = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_V2, S_V3, S_UV3, S_V6, S_V7, S_UV7,
    S_PSQ, S_PMUL, S_PEND, S_XM, S_C1, S_C2, S_UNI, S_XI, S_FIX, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } mul_ctl_t;

  // Fold a value below 2*p into [0, p).
  function automatic logic [FeW-1:0] canon(input logic [FeW:0] x);
    logic [FeW:0] s;
    begin
      s = x - {1'b0, PrimeP};
      canon = s[FeW] ? x[FeW-1:0] : s[FeW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/f25519_mul.sv =====
// Digit-serial modular multiplier: one 4-bit digit of b per cycle,
// most significant first, with a fold by 2^255 = 19 after each shift.
// A product takes 64 digit steps; done pulses the cycle after the last.
module f25519_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  f25519_pkg::mul_ctl_t          ctl,
  input  logic [f25519_pkg::FeW-1:0]    a,
  input  logic [f25519_pkg::FeW-1:0]    b,
  output logic                          done,
  output logic [f25519_pkg::FeW-1:0]    p
);
  logic [f25519_pkg::FeW-1:0]                  acc;
  logic [f25519_pkg::FeW:0]                    breg;
  logic [f25519_pkg::FeW-1:0]                  areg;
  logic [f25519_pkg::CntW-1:0]                 cnt;
  logic                                        run;
  logic [f25519_pkg::FeW+f25519_pkg::DigW:0]   sh;
  logic [f25519_pkg::FeW+f25519_pkg::DigW+1:0] sum;
  logic [f25519_pkg::DigW+1:0]                 hi;
  logic [f25519_pkg::DigW+6:0]                 hi19;
  logic [f25519_pkg::FeW:0]                    fold;
  logic [f25519_pkg::FeW:0]                    red;

  always_comb begin
    sh   = {{(f25519_pkg::DigW+1){1'b0}}, acc} << f25519_pkg::DigW;
    sum  = {1'b0, sh}
         + {{(f25519_pkg::DigW+2){1'b0}}, areg}
         * {{(f25519_pkg::FeW+2){1'b0}},
            breg[f25519_pkg::FeW -: f25519_pkg::DigW]};
    hi   = sum[f25519_pkg::FeW+f25519_pkg::DigW+1:f25519_pkg::FeW];
    hi19 = {5'b0, hi} * (f25519_pkg::DigW+7)'(19);
    fold = {1'b0, sum[f25519_pkg::FeW-1:0]}
         + {{(f25519_pkg::FeW-f25519_pkg::DigW-6){1'b0}}, hi19};
    red  = {1'b0, fold[f25519_pkg::FeW-1:0]}
         + (fold[f25519_pkg::FeW] ? (f25519_pkg::FeW+1)'(19) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= run && (cnt == f25519_pkg::CntW'(f25519_pkg::NDig-1));
      if (ctl.start && !run && !done) begin
        run  <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        areg <= a;
        breg <= {1'b0, b};
      end else if (run) begin
        acc  <= f25519_pkg::canon(red);
        breg <= breg << f25519_pkg::DigW;
        cnt  <= cnt + f25519_pkg::CntW'(1);
        if (cnt == f25519_pkg::CntW'(f25519_pkg::NDig-1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  assign p = acc;
endmodule

// ===== rtl/core/field25519_exponent_unit.sv =====
// Field exponent unit for p = 2^255-19. One word in, one word out: each word
// carries an opcode and two 255-bit operands, reduced mod p on entry, and the
// result is canonical. Every multiply or square runs on one shared
// digit-serial multiplier, in 64 four-bit digit steps between start and
// result. An exponent walks all 255 bits by square and multiply, with an
// advance step after each bit; this computes an inverse, a power 2^252-3,
// or a ratio square root (11 extra multiplies and a sign fix), and the
// unused opcode gives zero. The block holds one word at a time: in_stall
// stays high while it computes and while a result waits, and a new word
// can be accepted the cycle after the result is taken.
`include "field25519_exponent_unit_macros.svh"
module field25519_exponent_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [63:0] a_word0,
  input  logic [63:0] a_word1,
  input  logic [63:0] a_word2,
  input  logic [62:0] a_word3,
  input  logic [63:0] v_word0,
  input  logic [63:0] v_word1,
  input  logic [63:0] v_word2,
  input  logic [62:0] v_word3,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] r_word0,
  output logic [63:0] r_word1,
  output logic [63:0] r_word2,
  output logic [62:0] r_word3,
  output logic        is_square
);
  localparam int W = f25519_pkg::FeW;

  f25519_pkg::state_t state, state_next;
  f25519_pkg::op_t    op;
  logic [W-1:0] u, v, x, t, w, base, expo;
  logic [7:0]   bitcnt;
  logic [W-1:0] ma, mb, mp;
  logic         mdone, mstart;
  logic         sq;
  logic [W-1:0] res;
  f25519_pkg::mul_ctl_t mctl;
  logic [W-1:0] un;

  assign un = f25519_pkg::canon({1'b0, f25519_pkg::PrimeP - u});

  assign mctl.start = mstart;

  f25519_mul u_mul (.clk(clk), .rst(rst), .ctl(mctl), .a(ma), .b(mb),
                    .done(mdone), .p(mp));

  assign in_stall = (state != f25519_pkg::S_IDLE) || out_valid;

  // Operand select and sequencing.
  always_comb begin
    state_next = state;
    mstart = 1'b0;
    ma = t; mb = t;
    unique case (state)
      f25519_pkg::S_IDLE: ;
      f25519_pkg::S_LOAD: state_next = (op == f25519_pkg::OP_SQRT) ? f25519_pkg::S_V2 :
                             (op == f25519_pkg::OP_NONE) ? f25519_pkg::S_OUT : f25519_pkg::S_PSQ;
      f25519_pkg::S_V2:  begin ma = v; mb = v; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_V3; end
      f25519_pkg::S_V3:  begin ma = t; mb = v; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_UV3; end
      f25519_pkg::S_UV3: begin ma = u; mb = t; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_V6; end
      f25519_pkg::S_V6:  begin ma = t; mb = t; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_V7; end
      f25519_pkg::S_V7:  begin ma = t; mb = v; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_UV7; end
      f25519_pkg::S_UV7: begin ma = u; mb = t; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_PSQ; end
      f25519_pkg::S_PSQ: begin ma = x; mb = x; mstart = 1'b1;
                           if (mdone) state_next = expo[W-1] ? f25519_pkg::S_PMUL
                                                             : f25519_pkg::S_PEND; end
      f25519_pkg::S_PMUL: begin ma = x; mb = base; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_PEND; end
      f25519_pkg::S_PEND: state_next = (bitcnt != 8'd0) ? f25519_pkg::S_PSQ :
                             (op == f25519_pkg::OP_SQRT) ? f25519_pkg::S_XM : f25519_pkg::S_OUT;
      f25519_pkg::S_XM:  begin ma = x; mb = w; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_C1; end
      f25519_pkg::S_C1:  begin ma = x; mb = x; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_C2; end
      f25519_pkg::S_C2:  begin ma = t; mb = v; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_UNI; end
      f25519_pkg::S_UNI: begin ma = un; mb = f25519_pkg::SqrtM1; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_XI; end
      f25519_pkg::S_XI:  begin ma = x; mb = f25519_pkg::SqrtM1; mstart = 1'b1;
                           if (mdone) state_next = f25519_pkg::S_FIX; end
      f25519_pkg::S_FIX: state_next = f25519_pkg::S_OUT;
      f25519_pkg::S_OUT: state_next = f25519_pkg::S_IDLE;
      default:           state_next = f25519_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= f25519_pkg::S_IDLE;
    else if (state == f25519_pkg::S_IDLE) begin
      if (in_valid && !in_stall) state <= f25519_pkg::S_LOAD;
    end else state <= state_next;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == f25519_pkg::S_IDLE && in_valid && !in_stall) begin
        op <= f25519_pkg::op_t'(opcode);
        u  <= f25519_pkg::canon({1'b0, a_word3, a_word2, a_word1, a_word0});
        v  <= f25519_pkg::canon({1'b0, v_word3, v_word2, v_word1, v_word0});
        sq <= 1'b0;
      end
      unique case (state)
        f25519_pkg::S_LOAD: begin
          x      <= {{(W-1){1'b0}}, 1'b1};
          bitcnt <= 8'(W-1);
          expo   <= (op == f25519_pkg::OP_INV) ? f25519_pkg::ExpInv : f25519_pkg::Exp22523;
          base   <= u;
        end
        f25519_pkg::S_V2, f25519_pkg::S_V3, f25519_pkg::S_V6, f25519_pkg::S_V7,
        f25519_pkg::S_C1, f25519_pkg::S_C2:
          if (mdone) t <= mp;
        f25519_pkg::S_UV3: if (mdone) begin w <= mp; t <= t; end
        f25519_pkg::S_UV7: if (mdone) base <= mp;
        f25519_pkg::S_PSQ, f25519_pkg::S_PMUL, f25519_pkg::S_XM: if (mdone) x <= mp;
        f25519_pkg::S_PEND: begin expo <= expo << 1; bitcnt <= bitcnt - 8'd1; end
        f25519_pkg::S_UNI: if (mdone) w <= mp;
        f25519_pkg::S_XI: if (mdone) begin
          sq <= (t == u) || (t == un);
          if ((t == un) || (t == w)) x <= mp;
        end
        f25519_pkg::S_FIX:
          if (x[0]) x <= f25519_pkg::canon({1'b0, f25519_pkg::PrimeP - x});
        f25519_pkg::S_OUT: begin
          res <= (op == f25519_pkg::OP_NONE) ? '0 : x;
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign r_word0 = res[63:0];
  assign r_word1 = res[127:64];
  assign r_word2 = res[191:128];
  assign r_word3 = res[254:192];
  assign is_square = sq && (op == f25519_pkg::OP_SQRT);

  `FEU_ASSERT_IMPL(a_no_accept_busy, state != f25519_pkg::S_IDLE, in_stall, "accept while busy")
  `FEU_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid, "result dropped")
  `FEU_ASSERT_IMPL(a_canon, out_valid, res < f25519_pkg::PrimeP, "result not canonical")
endmodule
